// File: sv/csv_field_splitter_macros.svh
// Assertion macros for the CSV field splitter.
// CSVFS_ASSERT is disabled while reset is high; CSVFS_ASSERT_RESET is always checked.
`ifndef CSV_FIELD_SPLITTER_MACROS_SVH
`define CSV_FIELD_SPLITTER_MACROS_SVH
`ifndef SYNTHESIS
`define CSVFS_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define CSVFS_ASSERT_RESET(name, clk, prop, msg) \
   name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CSVFS_ASSERT(name, clk, rst, prop, msg)
`define CSVFS_ASSERT_RESET(name, clk, prop, msg)
`endif
`endif

// File: sv/csvfs_pkg.sv
package csvfs_pkg;

   // separator window, in bytes (the register holds at most four)
   localparam int SEP_MAX = 4;
   localparam int WIN_W   = 8 * SEP_MAX;

   localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
   localparam logic [1:0] SHORT_ROW    = 2'd2;

   // result kinds
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_FIELD    = 2'd0;
   localparam kind_type KIND_TOO_FEW  = 2'd1;
   localparam kind_type KIND_TOO_MANY = 2'd2;
   localparam kind_type KIND_DONE     = 2'd3;

   // register indexes
   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_SEP_BYTES  = 2'd0;
   localparam csr_index_type CSR_SEP_LENGTH = 2'd1;
   localparam csr_index_type CSR_TRIM       = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_file;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] field_offset;
      logic [31:0] field_length;
      logic [15:0] column_index;
      logic [31:0] row_index;
      logic        row_final;
      logic        last_of_run;
   } rsp_type;

endpackage

// File: sv/csv_field_splitter.sv
// Channel | Direction | Payload               | Handshake
// req     | in        | csvfs_pkg::req_type   | req_valid / req_ready
// rsp     | out       | csvfs_pkg::rsp_type   | rsp_valid / rsp_ready
// csr     | in        | index 2b, data 32b    | csr_write_enable, no wait
//
// One byte is taken per clock; each byte is parsed in the cycle it is accepted and its
// zero, one or two results enter a four-entry result queue, drained one per clock while
// rsp_ready is high. req_ready is low while the queue holds more than two results, so a
// sustained run of two-result bytes goes at the output rate of one result per clock.
// Reset is synchronous: parser state, queue pointers and registers return to reset values.
`include "csv_field_splitter_macros.svh"

module csv_field_splitter (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  csvfs_pkg::req_type       req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output csvfs_pkg::rsp_type       rsp_data,
   input  logic                     csr_write_enable,
   input  csvfs_pkg::csr_index_type csr_index,
   input  logic [31:0]              csr_write_data
);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // configuration
   logic [31:0] sep_bytes_ff;
   logic [2:0]  sep_len_ff;
   logic        trim_ff;

   // parser state
   logic [csvfs_pkg::WIN_W-1:0] recent_ff, recent_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] fstart_ff, fstart_in;
   logic [31:0] first_ff, first_in;
   logic [31:0] last_ff, last_in;
   logic        seen_ff, seen_in;
   logic [15:0] col_ff, col_in;
   logic [15:0] expect_ff, expect_in;
   logic [31:0] row_ff, row_in;
   logic [1:0]  rbytes_ff, rbytes_in;
   logic        held_ff, held_in;
   logic        stopped_ff, stopped_in;

   // result queue
   csvfs_pkg::rsp_type  queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   fill_ff, fill_in;

   logic               req_accept;
   logic               rsp_pop;
   logic [1:0]         push_n;
   csvfs_pkg::rsp_type slot0, slot1;

   function automatic logic is_blank(input logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B || c == 8'h0C ||
             c == 8'h0D;
   endfunction

   // field result, trimmed when enabled
   function automatic csvfs_pkg::rsp_type field_rsp(
      input logic        trim,
      input logic [31:0] s,
      input logic [31:0] e,
      input logic        sn,
      input logic [31:0] f,
      input logic [31:0] l,
      input logic [15:0] col,
      input logic [31:0] row,
      input logic        fin
   );
      csvfs_pkg::rsp_type r;
      r.kind         = csvfs_pkg::KIND_FIELD;
      r.field_offset = s;
      r.field_length = e - s;
      if (trim) begin
         r.field_offset = sn ? f : e;
         r.field_length = sn ? (l - f + 32'd1) : 32'd0;
      end
      r.column_index = col;
      r.row_index    = row;
      r.row_final    = fin;
      r.last_of_run  = 1'b0;
      return r;
   endfunction

   function automatic csvfs_pkg::rsp_type ctl_rsp(
      input csvfs_pkg::kind_type k,
      input logic [31:0]         row
   );
      csvfs_pkg::rsp_type r;
      r              = '0;
      r.kind         = k;
      r.row_index    = row;
      return r;
   endfunction

   assign req_ready  = fill_ff <= QCNT_W'(QUEUE_DEPTH - 2);
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = fill_ff != '0;
   assign rsp_pop    = rsp_valid && rsp_ready;
   assign rsp_data   = queue_ff[rd_ptr_ff];

   // single-pass byte parser
   always_comb begin
      logic [2:0]                  sep_len;
      logic [1:0]                  lm1;
      logic [1:0]                  sidx;
      logic [31:0]                 field_span;
      logic [csvfs_pkg::WIN_W-1:0] win_new;
      logic                        nl, eof;
      logic                        lv;
      logic [31:0]                 lpos;
      logic                        seen_a, seen_c;
      logic [31:0]                 first_a, last_a, first_c, last_c;
      logic                        hit, at_limit, hv, held_b;
      logic [15:0]                 limit, col_b;
      logic [16:0]                 col_inc;
      logic [31:0]                 fs_b, e_row, cnt, qpos;
      logic                        row_end, short_row, few, row_ok, row_err, dv;
      logic [1:0]                  rb_b, n;
      csvfs_pkg::rsp_type          r_hit, r_row, r_done;

      // clamp separator length to 1..SEP_MAX
      sep_len = sep_len_ff;
      if (sep_len == 3'd0) sep_len = 3'd1;
      if (sep_len > 3'(csvfs_pkg::SEP_MAX)) sep_len = 3'(csvfs_pkg::SEP_MAX);
      lm1 = 2'(sep_len - 3'd1);

      field_span = pos_ff - fstart_ff;
      win_new    = {recent_ff[csvfs_pkg::WIN_W-9:0], req_data.data_byte};
      nl         = req_data.data_byte == csvfs_pkg::NEWLINE_BYTE;
      eof        = req_data.end_of_file;

      // byte leaving the window belongs to the field
      lv      = field_span >= 32'(sep_len);
      lpos    = pos_ff - 32'(sep_len);
      seen_a  = seen_ff;
      first_a = first_ff;
      last_a  = last_ff;
      if (lv && !is_blank(recent_ff[8*lm1 +: 8])) begin
         if (!seen_ff) first_a = lpos;
         seen_a = 1'b1;
         last_a = lpos;
      end

      // separator match, first separator byte against the oldest window byte
      hit = !nl && (field_span >= 32'(lm1));
      for (int i = 0; i < csvfs_pkg::SEP_MAX; i++) begin
         sidx = 2'(lm1 - 2'(i));
         if (3'(i) < sep_len && win_new[8*sidx +: 8] != sep_bytes_ff[8*i +: 8]) hit = 1'b0;
      end

      limit    = (expect_ff != 16'd0) ? expect_ff : 16'hFFFF;
      col_inc  = {1'b0, col_ff} + 17'd1;
      at_limit = col_inc >= {1'b0, limit};
      hv       = hit && !held_ff && !at_limit;
      held_b   = held_ff || (hit && !held_ff && at_limit);
      col_b    = hv ? col_inc[15:0] : col_ff;
      fs_b     = hit ? pos_ff + 32'd1 : fstart_ff;
      r_hit    = field_rsp(trim_ff, fstart_ff, pos_ff - 32'(lm1), seen_a, first_a, last_a,
                           col_ff, row_ff, 1'b0);

      // row end: note the bytes still in the window, oldest first
      row_end = nl || eof;
      e_row   = nl ? pos_ff : pos_ff + 32'd1;
      cnt     = e_row - fs_b;
      seen_c  = hit ? 1'b0 : seen_a;
      first_c = first_a;
      last_c  = last_a;
      for (int k = csvfs_pkg::SEP_MAX - 1; k >= 0; k--) begin
         qpos = pos_ff - 32'(k);
         if (row_end && 3'(k) < sep_len && (qpos - fs_b) < cnt &&
             !is_blank(win_new[8*k +: 8])) begin
            if (!seen_c) first_c = qpos;
            seen_c = 1'b1;
            last_c = qpos;
         end
      end

      // judge the row
      rb_b      = (nl || rbytes_ff >= csvfs_pkg::SHORT_ROW) ? rbytes_ff : rbytes_ff + 2'd1;
      short_row = expect_ff != 16'd0 && rb_b < csvfs_pkg::SHORT_ROW;
      few       = expect_ff != 16'd0 && ({1'b0, col_b} + 17'd1) < {1'b0, expect_ff};
      row_ok    = row_end && !short_row && !held_b && !few;
      row_err   = row_end && !row_ok;
      r_row     = field_rsp(trim_ff, fs_b, e_row, seen_c, first_c, last_c, col_b, row_ff,
                            1'b1);
      if (short_row)   r_row = ctl_rsp(csvfs_pkg::KIND_DONE, row_ff);
      else if (held_b) r_row = ctl_rsp(csvfs_pkg::KIND_TOO_MANY, row_ff);
      else if (few)    r_row = ctl_rsp(csvfs_pkg::KIND_TOO_FEW, row_ff);
      dv     = row_ok && eof && nl;
      r_done = ctl_rsp(csvfs_pkg::KIND_DONE, row_ff + 32'd1);

      // order results: separator field, row result, then done
      n     = 2'(hv) + 2'(row_end) + 2'(dv);
      slot0 = hv ? r_hit : r_row;
      slot1 = hv ? r_row : r_done;
      slot0.last_of_run = n == 2'd1;
      slot1.last_of_run = 1'b1;

      // next state
      recent_in  = recent_ff;
      pos_in     = pos_ff;
      fstart_in  = fstart_ff;
      first_in   = first_ff;
      last_in    = last_ff;
      seen_in    = seen_ff;
      col_in     = col_ff;
      expect_in  = expect_ff;
      row_in     = row_ff;
      rbytes_in  = rbytes_ff;
      held_in    = held_ff;
      stopped_in = stopped_ff;
      push_n     = 2'd0;
      if (req_accept && !stopped_ff) begin
         recent_in  = win_new;
         pos_in     = pos_ff + 32'd1;
         fstart_in  = fs_b;
         first_in   = first_c;
         last_in    = last_c;
         seen_in    = seen_c;
         col_in     = col_b;
         rbytes_in  = rb_b;
         held_in    = held_b;
         stopped_in = eof || row_err;
         push_n     = n;
         if (row_ok) begin
            if (expect_ff == 16'd0) expect_in = col_b + 16'd1;
            row_in    = row_ff + 32'd1;
            col_in    = 16'd0;
            rbytes_in = 2'd0;
            held_in   = 1'b0;
            fstart_in = pos_ff + 32'd1;
            seen_in   = 1'b0;
         end
      end

      fill_in = fill_ff + QCNT_W'(push_n) - QCNT_W'(rsp_pop);
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         sep_bytes_ff <= 32'd44;
         sep_len_ff   <= 3'd1;
         trim_ff      <= 1'b0;
         recent_ff    <= '0;
         pos_ff       <= '0;
         fstart_ff    <= '0;
         first_ff     <= '0;
         last_ff      <= '0;
         seen_ff      <= 1'b0;
         col_ff       <= '0;
         expect_ff    <= '0;
         row_ff       <= '0;
         rbytes_ff    <= '0;
         held_ff      <= 1'b0;
         stopped_ff   <= 1'b0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         fill_ff      <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               csvfs_pkg::CSR_SEP_BYTES:  sep_bytes_ff <= csr_write_data;
               csvfs_pkg::CSR_SEP_LENGTH: sep_len_ff   <= csr_write_data[2:0];
               csvfs_pkg::CSR_TRIM:       trim_ff      <= csr_write_data[0];
               default: ;
            endcase
         end
         recent_ff  <= recent_in;
         pos_ff     <= pos_in;
         fstart_ff  <= fstart_in;
         first_ff   <= first_in;
         last_ff    <= last_in;
         seen_ff    <= seen_in;
         col_ff     <= col_in;
         expect_ff  <= expect_in;
         row_ff     <= row_in;
         rbytes_ff  <= rbytes_in;
         held_ff    <= held_in;
         stopped_ff <= stopped_in;
         wr_ptr_ff  <= wr_ptr_ff + QPTR_W'(push_n);
         rd_ptr_ff  <= rd_ptr_ff + QPTR_W'(rsp_pop);
         fill_ff    <= fill_in;
      end
   end

   // result queue payload
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) queue_ff[wr_ptr_ff] <= slot0;
      if (push_n == 2'd2) queue_ff[QPTR_W'(wr_ptr_ff + QPTR_W'(1))] <= slot1;
   end

   `CSVFS_ASSERT(a_fill_bound, clock, reset, fill_ff <= QCNT_W'(QUEUE_DEPTH), "queue overfull")
   `CSVFS_ASSERT(a_eof_stops, clock, reset,
      (req_accept && req_data.end_of_file) |=> stopped_ff, "eof did not stop parsing")
   `CSVFS_ASSERT(a_col_range, clock, reset, col_ff != 16'hFFFF, "column count overflow")
   `CSVFS_ASSERT(a_held_at_limit, clock, reset,
      held_ff |-> (expect_ff == 16'd0 || 17'(col_ff) + 17'd1 == 17'(expect_ff)),
      "row held below its column limit")
   `CSVFS_ASSERT_RESET(a_reset_clear, clock,
      reset |=> (fill_ff == '0 && !stopped_ff), "reset left state behind")

endmodule

// File: test/csv_field_splitter_tb.sv
module csv_field_splitter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned PHASES       = 8;
   localparam int unsigned PHASE_BYTES  = 190;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned CYCLE_LIMIT  = 400000;

   // how the file is closed; each one stops the parser for good
   typedef enum int unsigned {
      END_EOF_NEWLINE,
      END_EOF_TEXT,
      END_SHORT_ROW,
      END_TOO_FEW,
      END_TOO_MANY
   } file_end_type;

   // Predicts the field stream and holds the fields still owed by the block
   class field_scoreboard;
      logic [31:0]                 sep_bytes;
      logic [2:0]                  sep_len;
      logic                        trim_on;
      logic [csvfs_pkg::WIN_W-1:0] window;
      logic [31:0]                 pos;
      logic [31:0]                 field_start;
      logic [31:0]                 first_text;
      logic [31:0]                 last_text;
      logic                        text_seen;
      logic [15:0]                 column;
      logic [15:0]                 learned_columns;
      logic [31:0]                 row;
      logic [1:0]                  row_len;
      logic                        over_limit;
      logic                        halted;
      csvfs_pkg::rsp_type          step_results[$];
      csvfs_pkg::rsp_type          expected_fields[$];
      int unsigned                 errors;

      function new();
         sep_bytes       = 32'd44;
         sep_len         = 3'd1;
         trim_on         = 1'b0;
         window          = '0;
         pos             = '0;
         field_start     = '0;
         first_text      = '0;
         last_text       = '0;
         text_seen       = 1'b0;
         column          = '0;
         learned_columns = '0;
         row             = '0;
         row_len         = '0;
         over_limit      = 1'b0;
         halted          = 1'b0;
         errors          = 0;
      endfunction

      function void set_register(csvfs_pkg::csr_index_type idx, logic [31:0] value);
         case (idx)
            csvfs_pkg::CSR_SEP_BYTES:  sep_bytes = value;
            csvfs_pkg::CSR_SEP_LENGTH: sep_len   = value[2:0];
            csvfs_pkg::CSR_TRIM:       trim_on   = value[0];
            default: ;
         endcase
      endfunction

      // separator length as the block uses it, clamped to 1..SEP_MAX
      function int unsigned active_length();
         if (sep_len < 1) return 1;
         if (sep_len > csvfs_pkg::SEP_MAX) return csvfs_pkg::SEP_MAX;
         return 32'(sep_len);
      endfunction

      function int unsigned outstanding();
         return expected_fields.size();
      endfunction

      function bit is_blank(logic [7:0] c);
         return c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
      endfunction

      function logic [7:0] window_byte(int unsigned k);
         return window[8*k +: 8];
      endfunction

      function void mark_text(logic [31:0] at, logic [7:0] c);
         if (!is_blank(c)) begin
            if (!text_seen) begin
               first_text = at;
               text_seen  = 1'b1;
            end
            last_text = at;
         end
      endfunction

      function void add_result(csvfs_pkg::kind_type kind, logic [31:0] off,
                               logic [31:0] len, logic [15:0] col, logic [31:0] r,
                               logic fin);
         csvfs_pkg::rsp_type item;
         item.kind         = kind;
         item.field_offset = off;
         item.field_length = len;
         item.column_index = col;
         item.row_index    = r;
         item.row_final    = fin;
         item.last_of_run  = 1'b0;
         step_results.push_back(item);
      endfunction

      // a field spans [s, e); trimming narrows it to the non-blank bytes seen
      function void add_field(logic [31:0] s, logic [31:0] e, logic fin);
         logic [31:0] off;
         logic [31:0] len;
         off = s;
         len = e - s;
         if (trim_on) begin
            if (text_seen) begin
               off = first_text;
               len = last_text - first_text + 32'd1;
            end else begin
               off = e;
               len = '0;
            end
         end
         add_result(csvfs_pkg::KIND_FIELD, off, len, column, row, fin);
      endfunction

      // one accepted input transaction
      function void note_byte(csvfs_pkg::req_type item);
         logic [7:0]         b;
         logic               eof;
         logic               nl;
         logic               hit;
         logic [31:0]        p;
         logic [31:0]        d;
         logic [31:0]        e_row;
         logic [31:0]        cnt;
         logic [31:0]        q;
         logic [31:0]        limit;
         int unsigned        sl;
         csvfs_pkg::rsp_type r;
         if (halted) return;
         step_results.delete();
         b   = item.data_byte;
         eof = item.end_of_file;
         nl  = (b == csvfs_pkg::NEWLINE_BYTE);
         p   = pos;
         sl  = active_length();
         d   = p - field_start;

         // the byte leaving the separator window is certainly field text
         if (d >= sl) mark_text(p - sl, window_byte(sl - 1));
         window = {window[csvfs_pkg::WIN_W-9:0], b};

         if (!nl) begin
            if (row_len < csvfs_pkg::SHORT_ROW) row_len++;
            hit = (d >= sl - 1);
            for (int i = 0; i < sl; i++)
               if (window_byte(sl - 1 - i) != sep_bytes[8*i +: 8]) hit = 1'b0;
            if (hit) begin
               if (!over_limit) begin
                  limit = (learned_columns != 0) ? {16'd0, learned_columns} : 32'h0000_FFFF;
                  if ({16'd0, column} + 32'd1 >= limit) begin
                     over_limit = 1'b1;
                  end else begin
                     add_field(field_start, p - sl + 32'd1, 1'b0);
                     column++;
                  end
               end
               field_start = p + 32'd1;
               text_seen   = 1'b0;
            end
         end

         if (nl || eof) begin
            e_row = nl ? p : p + 32'd1;
            cnt   = e_row - field_start;
            // bytes still held in the window belong to the last field
            for (int k = sl - 1; k >= 0; k--) begin
               q = p - k;
               if (q - field_start < cnt) mark_text(q, window_byte(k));
            end
            if (learned_columns != 0 && row_len < csvfs_pkg::SHORT_ROW) begin
               add_result(csvfs_pkg::KIND_DONE, '0, '0, '0, row, 1'b0);
               halted = 1'b1;
            end else if (over_limit) begin
               add_result(csvfs_pkg::KIND_TOO_MANY, '0, '0, '0, row, 1'b0);
               halted = 1'b1;
            end else if (learned_columns != 0 &&
                         {16'd0, column} + 32'd1 < {16'd0, learned_columns}) begin
               add_result(csvfs_pkg::KIND_TOO_FEW, '0, '0, '0, row, 1'b0);
               halted = 1'b1;
            end else begin
               add_field(field_start, e_row, 1'b1);
               if (learned_columns == 0) learned_columns = column + 16'd1;
               row++;
               column      = '0;
               row_len     = '0;
               over_limit  = 1'b0;
               field_start = p + 32'd1;
               text_seen   = 1'b0;
               if (eof && nl) add_result(csvfs_pkg::KIND_DONE, '0, '0, '0, row, 1'b0);
            end
         end

         pos = p + 32'd1;
         if (eof) halted = 1'b1;
         foreach (step_results[i]) begin
            r = step_results[i];
            r.last_of_run = (i == step_results.size() - 1);
            expected_fields.push_back(r);
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            errors++;
         end
      endfunction

      // one accepted result transaction
      function void check_result(csvfs_pkg::rsp_type got);
         csvfs_pkg::rsp_type want;
         if (expected_fields.size() == 0) begin
            $error("result with nothing expected: kind %0d row %0d", got.kind, got.row_index);
            errors++;
            return;
         end
         want = expected_fields.pop_front();
         compare_field("kind", 32'(want.kind), 32'(got.kind));
         compare_field("field_offset", want.field_offset, got.field_offset);
         compare_field("field_length", want.field_length, got.field_length);
         compare_field("column_index", 32'(want.column_index), 32'(got.column_index));
         compare_field("row_index", want.row_index, got.row_index);
         compare_field("row_final", 32'(want.row_final), 32'(got.row_final));
         compare_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
      endfunction
   endclass

   logic                     clock            = 1'b0;
   logic                     reset            = 1'b1;
   logic                     req_valid        = 1'b0;
   logic                     req_ready;
   csvfs_pkg::req_type       req_data         = '0;
   logic                     rsp_valid;
   logic                     rsp_ready        = 1'b0;
   csvfs_pkg::rsp_type       rsp_data;
   logic                     csr_write_enable = 1'b0;
   csvfs_pkg::csr_index_type csr_index        = csvfs_pkg::CSR_SEP_BYTES;
   logic [31:0]              csr_write_data   = '0;

   field_scoreboard sb = new();

   // generator view of the separator and the current row text
   logic [31:0]   gen_sep = 32'd44;
   int unsigned   gen_len = 1;
   logic [7:0]    row_buf[$];
   int unsigned   column_total;
   int unsigned   sent_bytes = 0;
   int unsigned   cycle_count = 0;
   bit            sender_idles = 1'b1;
   bit            receiver_idles = 1'b1;
   bit            hold_request = 1'b0;

   csv_field_splitter i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #10 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // input first, so a result of this edge always finds its prediction
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_byte(req_data);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
      end
   end

   // result side: random stall bursts and one long hold-off
   initial begin : receiver
      bit hold_done;
      hold_done = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (receiver_idles && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic bit in_separator(logic [7:0] c);
      for (int i = 0; i < gen_len; i++)
         if (c == gen_sep[8*i +: 8]) return 1'b1;
      return 1'b0;
   endfunction

   // any byte that neither ends the row nor starts a separator
   function automatic logic [7:0] plain_byte();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == csvfs_pkg::NEWLINE_BYTE || in_separator(c));
      return c;
   endfunction

   // clean content keeps separator bytes out, blanks included
   function automatic logic [7:0] content_byte(bit noisy);
      logic [7:0]  blanks[5] = '{8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};
      logic [7:0]  c;
      int unsigned r;
      int unsigned k;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         c = blanks[$urandom_range(0, 4)];
         if (noisy || !in_separator(c)) return c;
         return plain_byte();
      end
      if (noisy && r < 30) begin
         k = $urandom_range(0, gen_len - 1);
         return gen_sep[8*k +: 8];
      end
      return plain_byte();
   endfunction

   // leftmost non-overlapping separator matches in the row
   function automatic int unsigned count_separators();
      int unsigned i;
      int unsigned hits;
      bit          m;
      i    = 0;
      hits = 0;
      while (i + gen_len <= row_buf.size()) begin
         m = 1'b1;
         for (int j = 0; j < gen_len; j++)
            if (row_buf[i+j] != gen_sep[8*j +: 8]) m = 1'b0;
         if (m) begin
            hits++;
            i += gen_len;
         end else begin
            i++;
         end
      end
      return hits;
   endfunction

   // Row of the given field count, at least two bytes long. Noisy content may
   // hold separator bytes; if that breaks the field count a clean row is used.
   function automatic void make_row(int unsigned fields, bit noisy);
      int unsigned width;
      for (int attempt = 0; attempt < 2; attempt++) begin
         row_buf.delete();
         for (int f = 0; f < fields; f++) begin
            if (f > 0)
               for (int j = 0; j < gen_len; j++) row_buf.push_back(gen_sep[8*j +: 8]);
            width = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(0, 6);
            repeat (width) row_buf.push_back(content_byte(noisy && attempt == 0));
         end
         while (row_buf.size() < 2) row_buf.push_front(plain_byte());
         if (count_separators() == fields - 1) return;
      end
   endfunction

   // one input transaction, with an occasional idle burst ahead of it
   task automatic send_byte(input logic [7:0] value, input logic last);
      if (sender_idles && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: value, end_of_file: last};
      sent_bytes++;
      do @(posedge clock);
      while (!req_ready);
   endtask

   task automatic send_row(input logic last);
      foreach (row_buf[i]) send_byte(row_buf[i], 1'b0);
      send_byte(csvfs_pkg::NEWLINE_BYTE, last);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // all three registers, on back-to-back cycles
   task automatic program_registers(input logic [31:0] sep, input logic [2:0] len,
                                    input logic trim);
      csr_write_enable <= 1'b1;
      csr_index        <= csvfs_pkg::CSR_SEP_BYTES;
      csr_write_data   <= sep;
      @(posedge clock);
      csr_index        <= csvfs_pkg::CSR_SEP_LENGTH;
      csr_write_data   <= {29'd0, len};
      @(posedge clock);
      csr_index        <= csvfs_pkg::CSR_TRIM;
      csr_write_data   <= {31'd0, trim};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_register(csvfs_pkg::CSR_SEP_BYTES, sep);
      sb.set_register(csvfs_pkg::CSR_SEP_LENGTH, {29'd0, len});
      sb.set_register(csvfs_pkg::CSR_TRIM, {31'd0, trim});
      gen_sep = sb.sep_bytes;
      gen_len = sb.active_length();
   endtask

   initial begin : stimulus
      file_end_type ending;
      int unsigned  phase_start;
      logic [31:0]  sep;
      logic [2:0]   len;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      column_total = $urandom_range(1, 5);
      ending       = file_end_type'($urandom_range(0, 4));
      if (ending == END_TOO_FEW && column_total == 1) ending = END_TOO_MANY;

      // header row of awkward fields, sent untrimmed and then trimmed
      for (int trim_pass = 0; trim_pass < 2; trim_pass++) begin
         program_registers(32'd44, 3'd1, trim_pass[0]);
         row_buf.delete();
         for (int c = 0; c < column_total; c++) begin
            if (c > 0) row_buf.push_back(8'h2C);
            case (c)
               0: begin
                  row_buf.push_back(8'h20);
                  row_buf.push_back(8'h61);
                  row_buf.push_back(8'h09);
               end
               1: ;
               2: begin
                  row_buf.push_back(8'h0B);
                  row_buf.push_back(8'h0C);
                  row_buf.push_back(8'h0D);
               end
               3: begin
                  row_buf.push_back(8'h00);
                  row_buf.push_back(8'hFF);
               end
               default: row_buf.push_back(8'h62);
            endcase
         end
         send_row(1'b0);
         wait_idle();
      end

      // random rows, a new separator and trim setting per phase
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               sep = 32'hFFFF_FFFF;
               len = 3'd7;
            end
            1: begin
               sep = 32'h0000_0000;
               len = 3'd0;
            end
            default: begin
               do sep = $urandom;
               while (sep[7:0] == csvfs_pkg::NEWLINE_BYTE ||
                      sep[15:8] == csvfs_pkg::NEWLINE_BYTE ||
                      sep[23:16] == csvfs_pkg::NEWLINE_BYTE ||
                      sep[31:24] == csvfs_pkg::NEWLINE_BYTE);
               len = 3'($urandom_range(0, 7));
            end
         endcase
         sender_idles   = (phase != 3) && (phase != PHASES - 1);
         receiver_idles = (phase != 3) && (phase != PHASES - 1);
         if (phase == 2) hold_request = 1'b1;
         program_registers(sep, len, 1'($urandom_range(0, 1)));
         phase_start = sent_bytes;
         while (sent_bytes - phase_start < PHASE_BYTES) begin
            make_row(column_total, $urandom_range(0, 2) == 0);
            send_row(1'b0);
         end
         wait_idle();
      end

      // close the file; this stops the parser
      case (ending)
         END_EOF_NEWLINE: begin
            make_row(column_total, 1'b0);
            send_row(1'b1);
         end
         END_EOF_TEXT: begin
            make_row(column_total, 1'b0);
            foreach (row_buf[i]) send_byte(row_buf[i], i == row_buf.size() - 1);
         end
         END_SHORT_ROW: begin
            case ($urandom_range(0, 2))
               0: send_byte(csvfs_pkg::NEWLINE_BYTE, 1'($urandom_range(0, 1)));
               1: begin
                  send_byte(plain_byte(), 1'b0);
                  send_byte(csvfs_pkg::NEWLINE_BYTE, 1'b0);
               end
               default: send_byte(plain_byte(), 1'b1);
            endcase
         end
         END_TOO_FEW: begin
            make_row($urandom_range(1, column_total - 1), 1'b0);
            send_row(1'b0);
         end
         default: begin
            make_row(column_total + $urandom_range(1, 3), 1'b0);
            send_row(1'b0);
         end
      endcase

      // bytes after the end are taken but give nothing
      repeat (4) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      wait_idle();
      repeat (20) @(posedge clock);

      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+sv
sv/csvfs_pkg.sv
sv/csv_field_splitter.sv
test/csv_field_splitter_tb.sv
